// ===== hw/rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants of the playout timing controller.
// Time widths, fixed-point constants, sequencer states and divider targets.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int TIME_W   = 32;
    localparam int SLACK_W  = TIME_W + 1;
    localparam int DUR_W    = 24;
    localparam int FRAC_W   = 17;
    localparam int XQ_W     = 18;
    localparam int CNT_W    = $clog2(TIME_W);

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [SLACK_W-1:0] SLACK_MAX = {1'b0, {TIME_W{1'b1}}};
    localparam logic [7:0]         RESYNC_RST = 8'd4;
    localparam logic [7:0]         ARR_MAX    = 8'd255;
    localparam logic [FRAC_W-1:0]  ONE_Q16    = FRAC_W'(65536);
    localparam logic [CNT_W-1:0]   CNT_LAST   = {CNT_W{1'b1}};

    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    localparam logic [1:0] OP_FIRST    = 2'd0;
    localparam logic [1:0] OP_START    = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;
    localparam logic [1:0] OP_QUEUED   = 2'd3;
    localparam logic [1:0] OP_NONE     = 2'd0;
    localparam logic [1:0] OP_ADVANCED = 2'd1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_ROLL  = 10'b00_0000_0010,
        S_CHK   = 10'b00_0000_0100,
        S_MULE  = 10'b00_0000_1000,
        S_MULC  = 10'b00_0001_0000,
        S_FRAC  = 10'b00_0010_0000,
        S_DIV   = 10'b00_0100_0000,
        S_SQ    = 10'b00_1000_0000,
        S_POLY  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        D_ELAP = 3'b001,
        D_CUR  = 3'b010,
        D_FRAC = 3'b100
    } t_dsel;

endpackage

// ===== hw/rtl/playout_timing_controller.sv =====
// ----------------------------------------------------------------------------
// playout_timing_controller
// Paces playout of received samples against the frame clock and reports an
// interpolation fraction on each frame tick.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  input   | i_valid/o_in_ready, action, duration,     | into the block
//          | frame_delta                               |
//  result  | o_valid/i_out_ready, op, fraction          | out of the block
//  config  | i_cfg_we/i_cfg_data (resync_count)        | into the block
//
// An arrival beat is handled in the cycle it is accepted; its result is
// offered in the next cycle. A tick beat runs through a small sequencer that
// reuses one restoring divider (one quotient bit per cycle) for the fraction
// and any speed-up correction. Reset (synchronous, active low) sets
// resync_count to 4 and clears all state but the divider and correction work.
// The block takes one beat at a time and holds its result until it is taken.
module playout_timing_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [23:0] i_sample_duration,
    input  logic [23:0] i_frame_delta,
    output logic        o_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_op,
    output logic [16:0] o_fraction,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);

    localparam int TW = ptc_pkg::TIME_W;
    localparam int SW = ptc_pkg::SLACK_W;

    ptc_pkg::t_state r_state;
    ptc_pkg::t_dsel  r_dsel;

    logic [1:0]    r_stage;
    logic [7:0]    r_count;
    logic [7:0]    r_resync;
    logic [TW-1:0] r_elap;
    logic [TW-1:0] r_cur;
    logic [TW-1:0] r_next;
    logic [SW-1:0] r_min;     // signed slack
    logic          r_corr;
    logic [TW-1:0] r_rem;
    logic [TW-1:0] r_tgt;

    // Shared divider: remainder, dividend/quotient shifter, divisor, step count.
    logic [TW-1:0]                 r_drem;
    logic [TW-1:0]                 r_quo;
    logic [TW-1:0]                 r_dvs;
    logic [ptc_pkg::CNT_W-1:0]     r_dcnt;
    logic [ptc_pkg::XQ_W-1:0]      r_x;
    logic [2*ptc_pkg::XQ_W-1:0]    r_sq;

    logic [1:0]  r_op;
    logic [16:0] r_frac;

    logic          accept;
    logic [TW:0]   elap_sum;
    logic [TW+2:0] slack_raw;
    logic [SW-1:0] slack_clamp;
    logic [TW:0]   dtrial;
    logic [TW:0]   next_sum;
    logic [TW+1:0] cur_x3;
    logic [SW-1:0] rem_s;
    logic [2*TW-1:0] prod;
    logic [TW+4:0] poly;

    assign o_in_ready = (r_state == ptc_pkg::S_IDLE);
    assign o_valid    = (r_state == ptc_pkg::S_DONE);
    assign o_op       = r_op;
    assign o_fraction = r_frac;
    assign accept     = i_valid && o_in_ready;

    // Slack of an arrival: next + current - elapsed - delta, clamped to the
    // signed range of the slack store.
    always_comb begin
        slack_raw = {3'b000, r_next} + {3'b000, r_cur} - {3'b000, r_elap}
                  - (TW+3)'(i_frame_delta);
        if (!slack_raw[TW+2] && slack_raw[TW+1:TW] != 2'b00) begin
            slack_clamp = ptc_pkg::SLACK_MAX;
        end else if (slack_raw[TW+2] && slack_raw[TW+1:TW] != 2'b11) begin
            slack_clamp = {1'b1, {TW{1'b0}}};
        end else begin
            slack_clamp = slack_raw[SW-1:0];
        end
    end

    assign elap_sum = {1'b0, r_elap} + (TW+1)'(i_frame_delta);
    assign next_sum = {1'b0, r_next} + (TW+1)'(i_sample_duration);
    assign dtrial   = {r_drem, r_quo[TW-1]};
    assign cur_x3   = {2'b00, r_cur} + {1'b0, r_cur, 1'b0};
    assign rem_s    = {1'b0, r_rem};
    assign prod     = (r_state == ptc_pkg::S_MULE) ? r_elap * r_tgt : r_cur * r_tgt;
    // Quadratic past one: (4x*2^16 - x*x - 2^32) / 2^17.
    assign poly     = {3'b000, r_x, 16'd0} + {1'b0, r_x, 18'd0} - {3'b000, r_x, 16'd0}
                    - (TW+5)'(r_sq) - (TW+5)'(64'h1_0000_0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ptc_pkg::S_IDLE;
            r_dsel   <= ptc_pkg::D_FRAC;
            r_stage  <= 2'd0;
            r_count  <= 8'd0;
            r_resync <= ptc_pkg::RESYNC_RST;
            r_elap   <= '0;
            r_cur    <= '0;
            r_next   <= '0;
            r_min    <= ptc_pkg::SLACK_MAX;
            r_corr   <= 1'b0;
            r_dcnt   <= '0;
            r_op     <= 2'd0;
            r_frac   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_resync <= i_cfg_data;
            end
            unique case (r_state)
                ptc_pkg::S_IDLE: begin
                    if (accept && i_action == ptc_pkg::ACT_ARRIVAL) begin
                        if ($signed(slack_clamp) < $signed(r_min)) begin
                            r_min <= slack_clamp;
                        end
                        if (r_count != ptc_pkg::ARR_MAX) begin
                            r_count <= r_count + 8'd1;
                        end
                        r_frac <= '0;
                        case (r_stage)
                            2'd0: begin
                                r_stage <= 2'd1;
                                r_op    <= ptc_pkg::OP_FIRST;
                            end
                            2'd1: begin
                                r_stage <= 2'd2;
                                r_elap  <= '0;
                                r_cur   <= TW'(i_sample_duration);
                                r_op    <= ptc_pkg::OP_START;
                            end
                            2'd2: begin
                                if (r_elap > r_cur) begin
                                    r_elap <= '0;
                                    r_cur  <= TW'(i_sample_duration);
                                    r_op   <= ptc_pkg::OP_RESTART;
                                end else begin
                                    r_stage <= 2'd3;
                                    r_next  <= TW'(i_sample_duration);
                                    r_op    <= ptc_pkg::OP_QUEUED;
                                end
                            end
                            default: begin
                                r_next <= next_sum[TW] ? ptc_pkg::TIME_MAX : next_sum[TW-1:0];
                                r_op   <= ptc_pkg::OP_QUEUED;
                            end
                        endcase
                        r_state <= ptc_pkg::S_DONE;
                    end else if (accept) begin
                        r_elap  <= elap_sum[TW] ? ptc_pkg::TIME_MAX : elap_sum[TW-1:0];
                        r_state <= ptc_pkg::S_ROLL;
                    end
                end
                ptc_pkg::S_ROLL: begin
                    if (r_stage == 2'd3 && r_elap > r_cur) begin
                        r_op    <= ptc_pkg::OP_ADVANCED;
                        r_stage <= 2'd2;
                        r_elap  <= r_elap - r_cur;
                        r_cur   <= r_next;
                        r_next  <= '0;
                        r_corr  <= (r_count >= r_resync);
                        r_rem   <= r_next - (r_elap - r_cur);
                        r_state <= ptc_pkg::S_CHK;
                    end else begin
                        r_op    <= ptc_pkg::OP_NONE;
                        r_state <= ptc_pkg::S_FRAC;
                    end
                end
                ptc_pkg::S_CHK: begin
                    r_state <= ptc_pkg::S_FRAC;
                    if (r_corr) begin
                        r_count <= 8'd0;
                        r_min   <= ptc_pkg::SLACK_MAX;
                        if ($signed(r_min) > 0 && r_cur > r_elap) begin
                            r_tgt   <= (rem_s > r_min) ? TW'(rem_s - r_min) : '0;
                            r_state <= ptc_pkg::S_MULE;
                        end
                    end
                end
                ptc_pkg::S_MULE, ptc_pkg::S_MULC: begin
                    r_drem  <= prod[2*TW-1:TW];
                    r_quo   <= prod[TW-1:0];
                    r_dvs   <= r_rem;
                    r_dcnt  <= '0;
                    r_dsel  <= (r_state == ptc_pkg::S_MULE) ? ptc_pkg::D_ELAP
                                                             : ptc_pkg::D_CUR;
                    r_state <= ptc_pkg::S_DIV;
                end
                ptc_pkg::S_FRAC: begin
                    if (r_cur == '0) begin
                        r_frac  <= '0;
                        r_state <= ptc_pkg::S_DONE;
                    end else if ({2'b00, r_elap} >= cur_x3) begin
                        r_frac  <= ptc_pkg::ONE_Q16;
                        r_state <= ptc_pkg::S_DONE;
                    end else begin
                        r_drem  <= {16'd0, r_elap[TW-1:16]};
                        r_quo   <= {r_elap[15:0], 16'd0};
                        r_dvs   <= r_cur;
                        r_dcnt  <= '0;
                        r_dsel  <= ptc_pkg::D_FRAC;
                        r_state <= ptc_pkg::S_DIV;
                    end
                end
                ptc_pkg::S_DIV: begin
                    if (dtrial >= {1'b0, r_dvs}) begin
                        r_drem <= TW'(dtrial - {1'b0, r_dvs});
                        r_quo  <= {r_quo[TW-2:0], 1'b1};
                    end else begin
                        r_drem <= dtrial[TW-1:0];
                        r_quo  <= {r_quo[TW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == ptc_pkg::CNT_LAST) begin
                        unique case (r_dsel)
                            ptc_pkg::D_ELAP: begin
                                r_elap  <= {r_quo[TW-2:0], dtrial >= {1'b0, r_dvs}};
                                r_state <= ptc_pkg::S_MULC;
                            end
                            ptc_pkg::D_CUR: begin
                                r_cur   <= {r_quo[TW-2:0], dtrial >= {1'b0, r_dvs}};
                                r_state <= ptc_pkg::S_FRAC;
                            end
                            default: begin
                                r_x     <= {r_quo[ptc_pkg::XQ_W-2:0], dtrial >= {1'b0, r_dvs}};
                                r_state <= ptc_pkg::S_SQ;
                            end
                        endcase
                    end
                end
                ptc_pkg::S_SQ: begin
                    if (r_x <= ptc_pkg::XQ_W'(ptc_pkg::ONE_Q16)) begin
                        r_frac  <= r_x[16:0];
                        r_state <= ptc_pkg::S_DONE;
                    end else begin
                        r_sq    <= r_x * r_x;
                        r_state <= ptc_pkg::S_POLY;
                    end
                end
                ptc_pkg::S_POLY: begin
                    r_frac  <= poly[33:17];
                    r_state <= ptc_pkg::S_DONE;
                end
                ptc_pkg::S_DONE: begin
                    if (i_out_ready) begin
                        r_state <= ptc_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= ptc_pkg::S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fraction <= 17'd98304)
        else $error("fraction out of range");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_valid))
        else $error("input ready while a result is pending");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("new beat taken before result delivered");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptc_pkg::S_DIV) |=>
            (r_state == ptc_pkg::S_DIV || $past(r_dcnt) == ptc_pkg::CNT_LAST))
        else $error("divider left early");
`endif

endmodule
